// ----- rtl/trrs_pkg.sv -----
// ----------------------------------------------------------------------------
// trrs_pkg
// Shared types and constants of the two-level round-robin scheduler.
// ----------------------------------------------------------------------------
package trrs_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);
   localparam int ID_W      = 8;
   localparam int Q_W       = 16;

   localparam logic [Q_W-1:0] QUANTUM_RESET = Q_W'(7);

   // Operation codes
   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_KILL   = 3'd1;
   localparam logic [2:0] OP_RAISE  = 3'd2;
   localparam logic [2:0] OP_LOWER  = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_HALTED  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_RESOLVE,
      S_MOVE,
      S_START,
      S_DONE
   } state_type;

   // Commands from the sequencer to the task list
   typedef struct packed {
      logic             mv_en;
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] dst;
      logic [ID_W-1:0]  mv_id;
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [ID_W-1:0]  wr_data;
      logic [IDX_W-1:0] rd_idx;
   } list_cmd_type;

endpackage

// ----- rtl/trrs_order.sv -----
// ----------------------------------------------------------------------------
// trrs_order
// Ordered task list: one scan read port, head tap, append write and a
// region shift that moves one entry from src to dst.
// ----------------------------------------------------------------------------
module trrs_order (
   input  logic                       clock,
   input  logic                       reset,
   input  trrs_pkg::list_cmd_type     cmd,
   output logic [trrs_pkg::ID_W-1:0]  rd_data,
   output logic [trrs_pkg::ID_W-1:0]  head
);
   import trrs_pkg::*;

   logic [ID_W-1:0] order_ff [MAX_TASKS];
   logic [ID_W-1:0] order_in [MAX_TASKS];

   assign rd_data = order_ff[cmd.rd_idx];
   assign head    = order_ff[0];

   // Shift the region between src and dst by one place, drop mv_id at dst
   always_comb begin
      for (int k = 0; k < MAX_TASKS; k++) begin
         order_in[k] = order_ff[k];
         if (cmd.mv_en) begin
            if (cmd.dst >= cmd.src) begin
               if (k < MAX_TASKS - 1 && IDX_W'(k) >= cmd.src && IDX_W'(k) < cmd.dst)
                  order_in[k] = order_ff[(k + 1) % MAX_TASKS];
            end else begin
               if (k > 0 && IDX_W'(k) > cmd.dst && IDX_W'(k) <= cmd.src)
                  order_in[k] = order_ff[(k + MAX_TASKS - 1) % MAX_TASKS];
            end
            if (IDX_W'(k) == cmd.dst) order_in[k] = cmd.mv_id;
         end else if (cmd.wr_en && IDX_W'(k) == cmd.wr_idx) begin
            order_in[k] = cmd.wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_TASKS; k++) order_ff[k] <= '0;
      end else begin
         for (int k = 0; k < MAX_TASKS; k++) order_ff[k] <= order_in[k];
      end
   end

endmodule

// ----- rtl/two_level_round_robin_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// two_level_round_robin_scheduler_top
// Task list with a high-priority prefix, quantum countdown and rotation.
//
//   channel | direction | word
//   req     | in        | tdata[2:0] op, [10:3] task_id
//   rsp     | out       | tdata[1:0] status, [9:2] new_id, [17:10] run_id,
//           |           |      [18] switched
//   csr     | in        | tdata[15:0] quantum_ticks
//
// From one accepted word to the next, a plain tick passes through decode,
// done and idle; a list search adds the scan state, which visits the
// entries in turn, and a resolve state; a list move and a head start add
// a state each. A single compare unit walks the list.
// req_tready is high only in idle. Reset loads id 0 as the only task.
// A result waiting on rsp_tready holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module two_level_round_robin_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op, task_id
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status, new_id, run_id, switched
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // quantum_ticks
);
   import trrs_pkg::*;

   state_type       state_ff, state_in;
   logic [2:0]      op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [CNT_W-1:0] count_ff, count_in, high_ff, high_in;
   logic            pend_ff, pend_in, halt_ff, halt_in;
   logic [Q_W-1:0]  qleft_ff, qleft_in, qticks_ff;
   logic [ID_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] scan_ff, scan_in, hi_ff, hi_in;
   logic            maxmode_ff, maxmode_in, found_ff, found_in;
   logic            wasrun_ff, wasrun_in, startaft_ff, startaft_in;
   logic [ID_W-1:0] max_ff, max_in;
   logic [IDX_W-1:0] pos_ff, pos_in, dst_ff, dst_in;
   logic [ID_W-1:0] mvid_ff, mvid_in;
   logic [1:0]      status_ff, status_in;
   logic [ID_W-1:0] newid_ff, newid_in;
   logic            sw_ff, sw_in;
   logic            rspv_ff, rspv_in;
   logic [23:0]     rspd_ff, rspd_in;

   list_cmd_type    cmd;
   logic [ID_W-1:0] rd_data, head;

   trrs_order u_order (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .head    (head)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rspd_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            state_in = S_DONE;
            if (!halt_ff) begin
               unique case (op_ff)
                  OP_CREATE, OP_KILL: state_in = S_SCAN;
                  OP_RAISE: begin
                     if (high_ff != '0) state_in = S_SCAN;
                     else if (head != id_ff && count_ff > CNT_W'(1)) state_in = S_SCAN;
                  end
                  OP_LOWER: begin
                     if (high_ff != '0) begin
                        if (head == id_ff) begin
                           if (count_ff > CNT_W'(1)) state_in = S_MOVE;
                        end else if (high_ff >= CNT_W'(2)) state_in = S_SCAN;
                     end
                  end
                  OP_TICK: begin
                     if (qleft_ff > Q_W'(1)) state_in = S_DONE;
                     else if (pend_ff) state_in = S_START;
                     else if (high_ff == CNT_W'(1) ||
                              (high_ff == '0 && count_ff == CNT_W'(1))) state_in = S_DONE;
                     else state_in = S_MOVE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff >= hi_ff) state_in = S_RESOLVE;
            else if (!maxmode_ff && rd_data == id_ff) state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            state_in = S_DONE;
            if (found_ff) begin
               if (op_ff != OP_KILL) state_in = S_MOVE;
               else if (count_ff != CNT_W'(1)) state_in = S_MOVE;
            end
         end
         S_MOVE:    state_in = startaft_ff ? S_START : S_DONE;
         S_START:   state_in = S_DONE;
         S_DONE:    if (!rspv_ff || rsp_tready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath and list commands
   always_comb begin
      op_in = op_ff;  id_in = id_ff;  count_in = count_ff;  high_in = high_ff;
      pend_in = pend_ff;  halt_in = halt_ff;  qleft_in = qleft_ff;  run_in = run_ff;
      scan_in = scan_ff;  hi_in = hi_ff;  maxmode_in = maxmode_ff;
      found_in = found_ff;  wasrun_in = wasrun_ff;  startaft_in = startaft_ff;
      max_in = max_ff;  pos_in = pos_ff;  dst_in = dst_ff;  mvid_in = mvid_ff;
      status_in = status_ff;  newid_in = newid_ff;  sw_in = sw_ff;
      rspv_in = rspv_ff;  rspd_in = rspd_ff;

      cmd         = '0;
      cmd.rd_idx  = scan_ff[IDX_W-1:0];
      cmd.src     = pos_ff;
      cmd.dst     = dst_ff;
      cmd.mv_id   = mvid_ff;

      // Drop the result once taken
      if (rspv_ff && rsp_tready) rspv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            op_in = req_tdata[2:0];
            id_in = req_tdata[10:3];
         end
         S_DECODE: begin
            status_in = ST_OK;  newid_in = '0;  sw_in = 1'b0;
            found_in = 1'b0;  max_in = '0;  maxmode_in = 1'b0;
            startaft_in = 1'b0;  scan_in = '0;  hi_in = count_ff;
            if (halt_ff) begin
               status_in = ST_HALTED;
            end else begin
               unique case (op_ff)
                  OP_CREATE: maxmode_in = 1'b1;
                  OP_KILL: ;
                  OP_RAISE: begin
                     if (high_ff != '0) begin
                        scan_in = high_ff;
                     end else if (head == id_ff) begin
                        high_in = CNT_W'(1);
                     end else if (count_ff > CNT_W'(1)) begin
                        high_in = CNT_W'(1);
                        scan_in = CNT_W'(1);
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  OP_LOWER: begin
                     if (high_ff == '0) begin
                        status_in = ST_MISS;
                     end else if (head == id_ff) begin
                        if (count_ff > CNT_W'(1)) begin
                           pend_in = 1'b1;
                           pos_in  = '0;
                           dst_in  = IDX_W'(count_ff - CNT_W'(1));
                           mvid_in = id_ff;
                        end
                        high_in = high_ff - CNT_W'(1);
                     end else if (high_ff >= CNT_W'(2)) begin
                        scan_in = CNT_W'(1);
                        hi_in   = high_ff;
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  OP_TICK: begin
                     if (qleft_ff > Q_W'(1)) begin
                        qleft_in = qleft_ff - Q_W'(1);
                     end else if (pend_ff) begin
                        // start served in S_START
                     end else if (high_ff == CNT_W'(1) ||
                                  (high_ff == '0 && count_ff == CNT_W'(1))) begin
                        qleft_in = qticks_ff;
                     end else begin
                        // rotate the high group, or the whole list
                        pos_in      = '0;
                        mvid_in     = head;
                        startaft_in = 1'b1;
                        dst_in      = (high_ff >= CNT_W'(2)) ?
                                      IDX_W'(high_ff - CNT_W'(1)) :
                                      IDX_W'(count_ff - CNT_W'(1));
                     end
                  end
                  default: status_in = ST_MISS;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff < hi_ff) begin
               if (maxmode_ff) begin
                  if (rd_data > max_ff) max_in = rd_data;
                  scan_in = scan_ff + CNT_W'(1);
               end else if (rd_data == id_ff) begin
                  found_in  = 1'b1;
                  pos_in    = scan_ff[IDX_W-1:0];
                  wasrun_in = (rd_data == run_ff);
               end else begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         S_RESOLVE: begin
            priority case (op_ff)
               OP_CREATE: begin
                  if (count_ff >= CNT_W'(MAX_TASKS) || max_ff == '1) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_idx  = count_ff[IDX_W-1:0];
                     cmd.wr_data = max_ff + ID_W'(1);
                     count_in    = count_ff + CNT_W'(1);
                     newid_in    = max_ff + ID_W'(1);
                  end
               end
               OP_KILL: begin
                  if (!found_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     if (CNT_W'(pos_ff) < high_ff) high_in = high_ff - CNT_W'(1);
                     count_in = count_ff - CNT_W'(1);
                     if (count_ff == CNT_W'(1)) begin
                        halt_in = 1'b1;
                        run_in  = '0;
                        pend_in = 1'b0;
                     end else begin
                        dst_in      = IDX_W'(count_ff - CNT_W'(1));
                        mvid_in     = id_ff;
                        startaft_in = (pos_ff == '0) || wasrun_ff;
                     end
                  end
               end
               OP_RAISE: begin
                  if (!found_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     dst_in  = high_ff[IDX_W-1:0];
                     mvid_in = id_ff;
                     high_in = high_ff + CNT_W'(1);
                  end
               end
               default: begin
                  if (!found_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     dst_in  = IDX_W'(count_ff - CNT_W'(1));
                     mvid_in = id_ff;
                     high_in = high_ff - CNT_W'(1);
                  end
               end
            endcase
         end
         S_MOVE:  cmd.mv_en = 1'b1;
         S_START: begin
            run_in   = head;
            qleft_in = qticks_ff;
            pend_in  = 1'b0;
            sw_in    = 1'b1;
         end
         S_DONE: begin
            if (!rspv_ff || rsp_tready) begin
               rspv_in = 1'b1;
               rspd_in = {5'd0, sw_ff, (halt_ff ? ID_W'(0) : run_ff), newid_ff, status_ff};
            end
         end
         default: ;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= CNT_W'(1);
         high_ff   <= '0;
         pend_ff   <= 1'b0;
         halt_ff   <= 1'b0;
         qleft_ff  <= QUANTUM_RESET;
         qticks_ff <= QUANTUM_RESET;
         run_ff    <= '0;
         rspv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         high_ff  <= high_in;
         pend_ff  <= pend_in;
         halt_ff  <= halt_in;
         qleft_ff <= qleft_in;
         run_ff   <= run_in;
         rspv_ff  <= rspv_in;
         if (csr_tvalid) qticks_ff <= csr_tdata;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      scan_ff     <= scan_in;
      hi_ff       <= hi_in;
      maxmode_ff  <= maxmode_in;
      found_ff    <= found_in;
      wasrun_ff   <= wasrun_in;
      startaft_ff <= startaft_in;
      max_ff      <= max_in;
      pos_ff      <= pos_in;
      dst_ff      <= dst_in;
      mvid_ff     <= mvid_in;
      status_ff   <= status_in;
      newid_ff    <= newid_in;
      sw_ff       <= sw_in;
      rspd_ff     <= rspd_in;
   end

endmodule
